// File: src/sorted_value_table_top_assert.svh
// Assertion macros for the sorted value table
`ifndef SORTED_VALUE_TABLE_TOP_ASSERT_SVH
`define SORTED_VALUE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SVT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/svt_pkg.sv
package svt_pkg;

   localparam int IDX_WIDTH   = 6;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_WIDTH   = 6;
   localparam int COUNT_WIDTH = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef struct packed {
      status_type             status;
      logic                   found;
      logic [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]   position;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

endpackage

// File: src/svt_mem.sv
module svt_mem #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/svt_seq.sv
module svt_seq #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = $clog2(DEPTH),
   parameter int CW         = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  svt_pkg::cmd_type            cmd,
   input  logic [DATA_WIDTH-1:0]       value,
   input  logic [svt_pkg::IDX_WIDTH-1:0] index,
   output logic                        done,
   output svt_pkg::rsp_type            rsp,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [DATA_WIDTH-1:0]       mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]       mem_rd_data
);

   import svt_pkg::*;

   localparam int CMPW = (CW > IDX_WIDTH) ? CW : IDX_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK
   } state_type;

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [IDX_WIDTH-1:0]  index_ff;
   logic [CW-1:0]         ptr_ff;
   logic [CW-1:0]         count_ff;
   logic                  shift_ff;
   logic                  done_ff;
   rsp_type               rsp_ff;

   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_dec;
   logic          scan_end;
   logic          slot_zero;
   logic          greater;
   logic          equal;
   logic          is_full;
   logic          out_of_range;

   assign ptr_dec      = ptr_ff - CW'(1);
   assign ptr_inc      = ptr_ff + CW'(1);
   assign count_inc    = count_ff + CW'(1);
   assign count_dec    = count_ff - CW'(1);
   assign scan_end     = (ptr_ff == count_ff);
   assign slot_zero    = (ptr_ff == '0);
   assign greater      = (mem_rd_data > value_ff);
   assign equal        = (mem_rd_data == value_ff);
   assign is_full      = (count_ff == CW'(DEPTH));
   assign out_of_range = (CMPW'(index) >= CMPW'(count_ff));

   // Memory port control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff[AW-1:0];
      mem_wr_data = value_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff[AW-1:0];
      case (state_ff)
         S_FETCH: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  if (slot_zero) begin
                     mem_wr_en = 1'b1;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ptr_dec[AW-1:0];
                  end
               end
               CMD_DELETE, CMD_SEARCH: begin
                  mem_rd_en = !scan_end;
               end
               CMD_READ: begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = AW'(index_ff);
               end
               default: ;
            endcase
         end
         S_CHECK: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  // move the larger entry up one slot, or drop the new value in
                  mem_wr_en   = 1'b1;
                  mem_wr_data = greater ? mem_rd_data : value_ff;
               end
               CMD_DELETE: begin
                  mem_wr_en   = shift_ff;
                  mem_wr_addr = ptr_dec[AW-1:0];
                  mem_wr_data = mem_rd_data;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (go) begin
                  cmd_ff          <= cmd;
                  value_ff        <= value;
                  index_ff        <= index;
                  shift_ff        <= 1'b0;
                  rsp_ff.status   <= ST_OK;
                  rsp_ff.found    <= 1'b0;
                  rsp_ff.value    <= '0;
                  rsp_ff.position <= '0;
                  rsp_ff.count    <= COUNT_WIDTH'(count_ff);
                  case (cmd)
                     CMD_INSERT: begin
                        if (is_full) begin
                           rsp_ff.status <= ST_FULL;
                           done_ff       <= 1'b1;
                        end else begin
                           ptr_ff   <= count_ff;
                           state_ff <= S_FETCH;
                        end
                     end
                     CMD_DELETE, CMD_SEARCH: begin
                        ptr_ff   <= '0;
                        state_ff <= S_FETCH;
                     end
                     CMD_READ: begin
                        if (out_of_range) begin
                           rsp_ff.status <= ST_RANGE;
                           done_ff       <= 1'b1;
                        end else begin
                           state_ff <= S_FETCH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_FETCH: begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (slot_zero) begin
                        count_ff     <= count_inc;
                        rsp_ff.count <= COUNT_WIDTH'(count_inc);
                        done_ff      <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        state_ff <= S_CHECK;
                     end
                  end
                  CMD_DELETE: begin
                     if (scan_end) begin
                        if (shift_ff) begin
                           count_ff     <= count_dec;
                           rsp_ff.count <= COUNT_WIDTH'(count_dec);
                           rsp_ff.found <= 1'b1;
                        end else begin
                           rsp_ff.status <= ST_ABSENT;
                        end
                        done_ff  <= 1'b1;
                        state_ff <= S_IDLE;
                     end else begin
                        state_ff <= S_CHECK;
                     end
                  end
                  CMD_SEARCH: begin
                     if (scan_end) begin
                        rsp_ff.status <= ST_ABSENT;
                        done_ff       <= 1'b1;
                        state_ff      <= S_IDLE;
                     end else begin
                        state_ff <= S_CHECK;
                     end
                  end
                  default: begin
                     state_ff <= S_CHECK;
                  end
               endcase
            end
            S_CHECK: begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (greater) begin
                        ptr_ff   <= ptr_dec;
                        state_ff <= S_FETCH;
                     end else begin
                        count_ff     <= count_inc;
                        rsp_ff.count <= COUNT_WIDTH'(count_inc);
                        done_ff      <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end
                  CMD_DELETE: begin
                     // start closing the gap after the first match
                     if (!shift_ff && equal) begin
                        shift_ff <= 1'b1;
                     end
                     ptr_ff   <= ptr_inc;
                     state_ff <= S_FETCH;
                  end
                  CMD_SEARCH: begin
                     if (equal) begin
                        rsp_ff.found    <= 1'b1;
                        rsp_ff.position <= POS_WIDTH'(ptr_ff);
                        done_ff         <= 1'b1;
                        state_ff        <= S_IDLE;
                     end else begin
                        ptr_ff   <= ptr_inc;
                        state_ff <= S_FETCH;
                     end
                  end
                  default: begin
                     rsp_ff.value <= VALUE_WIDTH'(mem_rd_data);
                     done_ff      <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign rsp  = rsp_ff;

endmodule

// File: src/sorted_value_table_top.sv
// Sorted value table: up to DEPTH values of DATA_WIDTH bits kept in ascending
// order, duplicates allowed, in a single-port-read, single-port-write RAM.
// Requests: drive req_command, req_value_in and req_index_in with start high;
// the request is taken at an edge where busy is low. Commands are insert,
// delete (first equal entry), search (first equal entry) and read at index.
// Each request yields exactly one response, shown for one cycle with
// rsp_strobe high; the receiver cannot hold it off. busy stays high from the
// accepting edge to the end of the strobe cycle.
// Each entry visited takes a RAM read in S_FETCH and a compare/write in
// S_CHECK. Insert walks down from the top entry to its slot, moving each
// larger entry up one slot; delete walks the whole table; search stops at
// the first match; read does a single RAM read at the index. A full insert
// or a read out of range answers straight from idle, with no RAM access.
// busy is low again as soon as the strobe cycle has ended.
// Reset empties the table (count to zero); no clearing pass is needed.
module sorted_value_table_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic [svt_pkg::VALUE_WIDTH-1:0] req_value_in,
   input  logic [svt_pkg::IDX_WIDTH-1:0]   req_index_in,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_found,
   output logic [svt_pkg::VALUE_WIDTH-1:0] rsp_value_out,
   output logic [svt_pkg::POS_WIDTH-1:0]   rsp_position,
   output logic [svt_pkg::COUNT_WIDTH-1:0] rsp_count
);

   import svt_pkg::*;

`include "sorted_value_table_top_assert.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                  busy_ff;
   logic                  accept;
   logic [DATA_WIDTH-1:0] value_masked;
   logic                  done;
   rsp_type               rsp;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   logic                  full_rsp;
   logic                  full_ok;
   logic                  absent_rsp;
   logic                  absent_ok;

   assign accept       = start && !busy_ff;
   // keep only the bits the table stores
   assign value_masked = DATA_WIDTH'(req_value_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   svt_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .go          (accept),
      .cmd         (cmd_type'(req_command)),
      .value       (value_masked),
      .index       (req_index_in),
      .done        (done),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   svt_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy          = busy_ff;
   assign rsp_strobe    = done;
   assign rsp_status    = rsp.status;
   assign rsp_found     = rsp.found;
   assign rsp_value_out = rsp.value;
   assign rsp_position  = rsp.position;
   assign rsp_count     = rsp.count;

   assign full_rsp   = done && (rsp.status == ST_FULL);
   assign full_ok    = (rsp.count == COUNT_WIDTH'(DEPTH));
   assign absent_rsp = done && (rsp.status == ST_ABSENT);
   assign absent_ok  = !rsp.found && (rsp.position == '0);

   `SVT_ASSERT_NOW(a_strobe_busy, clock, reset, done, busy_ff, "response without request")
   `SVT_ASSERT_NOW(a_full_count, clock, reset, full_rsp, full_ok, "full below capacity")
   `SVT_ASSERT_NOW(a_absent_clear, clock, reset, absent_rsp, absent_ok, "absent but found")
   `SVT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff, "busy not raised after request")

endmodule
